// ===== rtl/core/rdmc_pkg.sv =====
// Shared constants, control-word types, microprogram table and helpers for the maze carver.
`default_nettype none

package rdmc_pkg;

   localparam int MAZE_COLS   = 6;
   localparam int MAZE_ROWS   = 5;
   localparam int GRID_H      = 2 * MAZE_ROWS + 1;
   localparam int GRID_W      = 2 * MAZE_COLS + 1;
   localparam int STACK_DEPTH = MAZE_ROWS * MAZE_COLS;

   localparam int ROW_W   = $clog2(GRID_H);
   localparam int COL_W   = $clog2(GRID_W);
   localparam int ENTRY_W = ROW_W + COL_W;
   localparam int STK_AW  = $clog2(STACK_DEPTH);
   localparam int CNT_W   = $clog2(STACK_DEPTH + 1);

   localparam int POS_W      = 4;
   localparam int BITS_W     = 13;
   localparam int RND_W      = 15;
   localparam int IDX_W      = 4;
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;

   localparam logic [GRID_W-1:0] ALL_WALLS = {GRID_W{1'b1}};

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_STEP  = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      DIR_SOUTH = 2'd0,
      DIR_NORTH = 2'd1,
      DIR_WEST  = 2'd2,
      DIR_EAST  = 2'd3
   } dir_type;

   typedef logic [3:0] upc_type;

   localparam upc_type UP_IDLE    = 4'd0;
   localparam upc_type UP_START   = 4'd1;
   localparam upc_type UP_READ    = 4'd2;
   localparam upc_type UP_READ_LT = 4'd3;
   localparam upc_type UP_CHECK   = 4'd4;
   localparam upc_type UP_SCAN0   = 4'd5;
   localparam upc_type UP_SCAN1   = 4'd6;
   localparam upc_type UP_SCAN2   = 4'd7;
   localparam upc_type UP_SCAN3   = 4'd8;
   localparam upc_type UP_EVAL    = 4'd9;
   localparam upc_type UP_POP     = 4'd10;
   localparam upc_type UP_CARVE0  = 4'd11;
   localparam upc_type UP_CARVE1  = 4'd12;
   localparam upc_type UP_CARVE2  = 4'd13;
   localparam upc_type UP_RESP    = 4'd14;

   typedef enum logic [2:0] {
      GR_NONE, GR_SOUTH, GR_NORTH, GR_CUR, GR_WALL, GR_INDEX
   } grid_rd_type;

   typedef enum logic [2:0] {
      LT_NONE, LT_SOUTH, LT_NORTH, LT_CUR, LT_BITS
   } latch_type;

   typedef enum logic [1:0] {
      GW_NONE, GW_START, GW_WALL, GW_TARGET
   } grid_wr_type;

   typedef enum logic [1:0] {
      SK_NONE, SK_PUSH, SK_READ, SK_POP
   } stack_op_type;

   typedef enum logic [2:0] {
      JC_NEXT, JC_ALWAYS, JC_DISPATCH, JC_DONE, JC_MOVES, JC_POP, JC_RESP
   } jump_type;

   typedef struct packed {
      grid_rd_type  grid_rd;
      latch_type    latch;
      grid_wr_type  grid_wr;
      stack_op_type stack_op;
      logic         set_dir;
      jump_type     jump;
      upc_type      target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input upc_type pc);
      ucode_type uw;
      uw = '{grid_rd: GR_NONE, latch: LT_NONE, grid_wr: GW_NONE, stack_op: SK_NONE,
             set_dir: 1'b0, jump: JC_ALWAYS, target: UP_IDLE};
      case (pc)
         UP_IDLE: begin
            uw.jump = JC_DISPATCH;
         end
         UP_START: begin
            uw.grid_wr  = GW_START;
            uw.stack_op = SK_PUSH;
            uw.target   = UP_RESP;
         end
         UP_READ: begin
            uw.grid_rd = GR_INDEX;
            uw.jump    = JC_NEXT;
         end
         UP_READ_LT: begin
            uw.latch  = LT_BITS;
            uw.target = UP_RESP;
         end
         UP_CHECK: begin
            uw.jump   = JC_DONE;
            uw.target = UP_RESP;
         end
         UP_SCAN0: begin
            uw.grid_rd = GR_SOUTH;
            uw.jump    = JC_NEXT;
         end
         UP_SCAN1: begin
            uw.latch   = LT_SOUTH;
            uw.grid_rd = GR_NORTH;
            uw.jump    = JC_NEXT;
         end
         UP_SCAN2: begin
            uw.latch   = LT_NORTH;
            uw.grid_rd = GR_CUR;
            uw.jump    = JC_NEXT;
         end
         UP_SCAN3: begin
            uw.latch = LT_CUR;
            uw.jump  = JC_NEXT;
         end
         UP_EVAL: begin
            uw.stack_op = SK_READ;
            uw.jump     = JC_MOVES;
            uw.target   = UP_CARVE0;
         end
         UP_POP: begin
            uw.stack_op = SK_POP;
            uw.jump     = JC_POP;
            uw.target   = UP_SCAN0;
         end
         UP_CARVE0: begin
            uw.set_dir = 1'b1;
            uw.grid_rd = GR_WALL;
            uw.jump    = JC_NEXT;
         end
         UP_CARVE1: begin
            uw.grid_wr = GW_WALL;
            uw.jump    = JC_NEXT;
         end
         UP_CARVE2: begin
            uw.grid_wr  = GW_TARGET;
            uw.stack_op = SK_PUSH;
            uw.jump     = JC_NEXT;
         end
         UP_RESP: begin
            uw.jump   = JC_RESP;
            uw.target = UP_IDLE;
         end
         default: begin
            uw.target = UP_IDLE;
         end
      endcase
      return uw;
   endfunction

   // base-4 digit sum, since 4 is 1 mod 3
   function automatic logic [1:0] mod3_rnd(input logic [RND_W-1:0] v);
      logic [4:0] s;
      logic [2:0] t;
      logic [1:0] r;
      s = 5'(v[RND_W-1]);
      for (int i = 0; i < 7; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      case (t)
         3'd0, 3'd3, 3'd6: r = 2'd0;
         3'd1, 3'd4, 3'd7: r = 2'd1;
         3'd2, 3'd5:       r = 2'd2;
         default:          r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rdmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rdmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/random_dfs_maze_carver.sv =====
// Top level of the randomized depth-first maze carver: microcoded sequencer and datapath.
//
// Usage:
//   req channel: tuser carries the action (start, step, read row); tdata carries
//   random_value and row_index. rsp channel returns exactly one transfer per
//   request: current cell, direction taken, finished flag and row wall bits.
//   A request is taken only while the sequencer sits in its idle step.
// Sequencing: each request ends in the response step, which loads the output register.
//   A step on a finished maze goes straight to the response step. A step scans
//   the neighbours of the current cell, and again after every backtracked cell, with
//   a four-step scan that reads three grid rows through the single RAM read port.
// Throughput: one request at a time; a new request is taken the cycle after
//   the result is loaded into the output register.
// Stall: a result waiting on rsp_tready stays in the output register; the next
//   request is still accepted and its result is held until the register frees.
// Reset: grid reads as all walls (per-row valid bits), stack empty, current
//   cell (1,1), maze marked finished.
`default_nettype none

module random_dfs_maze_carver (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [14:0] random_value, [18:15] row_index, [23:19] zero
   input  wire logic [rdmc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] action
   input  wire logic [rdmc_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [3:0] cell_row, [7:4] cell_col, [9:8] direction, [10] finished, [23:11] row_bits
   output logic      [rdmc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   import rdmc_pkg::*;

   upc_type                upc_ff, upc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [ROW_W-1:0]       cur_row_ff, cur_row_in;
   logic [COL_W-1:0]       cur_col_ff, cur_col_in;
   logic [GRID_H-1:0]      valid_ff, valid_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [1:0]             dir_ff, dir_in;
   logic [BITS_W-1:0]      bits_ff, bits_in;
   logic [RND_W-1:0]       rnd_ff, rnd_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [GRID_W-1:0]      row_s_ff, row_s_in;
   logic [GRID_W-1:0]      row_n_ff, row_n_in;
   logic [GRID_W-1:0]      row_c_ff, row_c_in;

   ucode_type              uw;
   logic                   req_accept;
   logic                   rsp_load;

   logic [ROW_W:0]         r_ext, r_p2, r_m2;
   logic [COL_W:0]         c_ext, c_p2, c_m2;
   logic                   s_ok, n_ok, w_ok, e_ok, idx_ok;
   logic [3:0]             cand_mask;
   logic [2:0]             cand_n;
   logic [1:0]             cand_k;
   logic [1:0]             pick_dir;
   logic [1:0]             wall_dir;
   logic [ROW_W-1:0]       wall_row;
   logic [GRID_W-1:0]      one_c;
   logic [CNT_W-1:0]       cnt_m1;
   logic                   cnt_room;

   logic                   gr_en;
   logic [ROW_W-1:0]       gr_addr;
   logic [GRID_W-1:0]      gr_q, rd_eff;
   logic                   gw_en;
   logic [ROW_W-1:0]       gw_addr;
   logic [GRID_W-1:0]      gw_data;

   logic                   st_wr_en;
   logic [STK_AW-1:0]      st_wr_addr;
   logic [ENTRY_W-1:0]     st_wr_data;
   logic                   st_rd_en;
   logic [ENTRY_W-1:0]     st_q;
   logic [ROW_W-1:0]       new_row;
   logic [COL_W-1:0]       new_col;

   assign uw         = ucode_rom(upc_ff);
   assign req_tready = (upc_ff == UP_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // neighbor geometry
   assign r_ext  = {1'b0, cur_row_ff};
   assign c_ext  = {1'b0, cur_col_ff};
   assign r_p2   = r_ext + (ROW_W+1)'(2);
   assign r_m2   = r_ext - (ROW_W+1)'(2);
   assign c_p2   = c_ext + (COL_W+1)'(2);
   assign c_m2   = c_ext - (COL_W+1)'(2);
   assign s_ok   = r_p2 < (ROW_W+1)'(GRID_H - 1);
   assign n_ok   = r_ext >= (ROW_W+1)'(3);
   assign w_ok   = c_ext >= (COL_W+1)'(3);
   assign e_ok   = c_p2 < (COL_W+1)'(GRID_W - 1);
   assign idx_ok = idx_ff < IDX_W'(GRID_H);
   assign one_c  = GRID_W'(1) << cur_col_ff;
   assign cnt_m1 = count_ff - CNT_W'(1);
   assign cnt_room = count_ff < CNT_W'(STACK_DEPTH);

   assign rd_eff = rd_valid_ff ? gr_q : ALL_WALLS;

   always_comb begin
      cand_mask[DIR_SOUTH] = s_ok && row_s_ff[cur_col_ff];
      cand_mask[DIR_NORTH] = n_ok && row_n_ff[cur_col_ff];
      cand_mask[DIR_WEST]  = w_ok && row_c_ff[c_m2[COL_W-1:0]];
      cand_mask[DIR_EAST]  = e_ok && row_c_ff[c_p2[COL_W-1:0]];
   end

   always_comb begin
      logic [1:0] seen;
      logic       found;
      cand_n = 3'($countones(cand_mask));
      case (cand_n)
         3'd1:    cand_k = 2'd0;
         3'd2:    cand_k = {1'b0, rnd_ff[0]};
         3'd3:    cand_k = mod3_rnd(rnd_ff);
         default: cand_k = rnd_ff[1:0];
      endcase
      seen     = 2'd0;
      found    = 1'b0;
      pick_dir = DIR_SOUTH;
      for (int j = 0; j < 4; j++) begin
         if (cand_mask[j]) begin
            if (!found && seen == cand_k) begin
               pick_dir = 2'(j);
               found    = 1'b1;
            end
            seen = seen + 2'd1;
         end
      end
   end

   always_comb begin
      wall_dir = (uw.grid_wr == GW_WALL) ? dir_ff : pick_dir;
      case (wall_dir)
         DIR_SOUTH: wall_row = ROW_W'(r_ext + (ROW_W+1)'(1));
         DIR_NORTH: wall_row = ROW_W'(r_ext - (ROW_W+1)'(1));
         default:   wall_row = cur_row_ff;
      endcase
   end

   always_comb begin
      case (dir_ff)
         DIR_SOUTH: begin
            new_row = r_p2[ROW_W-1:0];
            new_col = cur_col_ff;
         end
         DIR_NORTH: begin
            new_row = r_m2[ROW_W-1:0];
            new_col = cur_col_ff;
         end
         DIR_WEST: begin
            new_row = cur_row_ff;
            new_col = c_m2[COL_W-1:0];
         end
         default: begin
            new_row = cur_row_ff;
            new_col = c_p2[COL_W-1:0];
         end
      endcase
   end

   // grid read port
   always_comb begin
      gr_en = (uw.grid_rd != GR_NONE);
      case (uw.grid_rd)
         GR_SOUTH: gr_addr = s_ok ? r_p2[ROW_W-1:0] : '0;
         GR_NORTH: gr_addr = n_ok ? r_m2[ROW_W-1:0] : '0;
         GR_CUR:   gr_addr = cur_row_ff;
         GR_WALL:  gr_addr = wall_row;
         GR_INDEX: gr_addr = idx_ok ? ROW_W'(idx_ff) : '0;
         default:  gr_addr = '0;
      endcase
   end

   // grid write port
   always_comb begin
      gw_en   = 1'b0;
      gw_addr = '0;
      gw_data = ALL_WALLS;
      case (uw.grid_wr)
         GW_START: begin
            gw_en   = 1'b1;
            gw_addr = ROW_W'(1);
            gw_data = ALL_WALLS & ~GRID_W'(2);
         end
         GW_WALL: begin
            gw_en   = 1'b1;
            gw_addr = wall_row;
            case (dir_ff)
               DIR_WEST: gw_data = rd_eff & ~(GRID_W'(3) << c_m2[COL_W-1:0]);
               DIR_EAST: gw_data = rd_eff & ~(GRID_W'(3) << COL_W'(c_ext + (COL_W+1)'(1)));
               default:  gw_data = rd_eff & ~one_c;
            endcase
         end
         GW_TARGET: begin
            gw_en   = (dir_ff == DIR_SOUTH) || (dir_ff == DIR_NORTH);
            gw_addr = new_row;
            gw_data = ((dir_ff == DIR_SOUTH) ? row_s_ff : row_n_ff) & ~one_c;
         end
         default: begin
            gw_en = 1'b0;
         end
      endcase
   end

   // stack ports
   always_comb begin
      st_rd_en   = (uw.stack_op == SK_READ);
      st_wr_en   = 1'b0;
      st_wr_addr = count_ff[STK_AW-1:0];
      st_wr_data = {new_row, new_col};
      if (uw.stack_op == SK_PUSH) begin
         if (uw.grid_wr == GW_START) begin
            st_wr_en   = 1'b1;
            st_wr_addr = '0;
            st_wr_data = {ROW_W'(1), COL_W'(1)};
         end else begin
            st_wr_en = cnt_room;
         end
      end
   end

   // sequencer and datapath next state
   always_comb begin
      upc_in       = upc_ff;
      rsp_load     = 1'b0;
      done_in      = done_ff;
      count_in     = count_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      valid_in     = valid_ff;
      rd_valid_in  = rd_valid_ff;
      dir_in       = dir_ff;
      bits_in      = bits_ff;
      rnd_in       = rnd_ff;
      idx_in       = idx_ff;
      row_s_in     = row_s_ff;
      row_n_in     = row_n_ff;
      row_c_in     = row_c_ff;

      if (req_accept) begin
         rnd_in  = req_tdata[RND_W-1:0];
         idx_in  = req_tdata[RND_W +: IDX_W];
         dir_in  = DIR_SOUTH;
         bits_in = '0;
      end

      if (gr_en) begin
         rd_valid_in = valid_ff[gr_addr];
      end

      case (uw.latch)
         LT_SOUTH: row_s_in = rd_eff;
         LT_NORTH: row_n_in = rd_eff;
         LT_CUR:   row_c_in = rd_eff;
         LT_BITS:  bits_in  = idx_ok ? BITS_W'(rd_eff) : '0;
         default:  ;
      endcase

      if (uw.set_dir) begin
         dir_in = pick_dir;
      end

      if (uw.grid_wr == GW_START) begin
         valid_in   = '0;
         done_in    = 1'b0;
         count_in   = CNT_W'(1);
         cur_row_in = ROW_W'(1);
         cur_col_in = COL_W'(1);
      end
      if (gw_en) begin
         valid_in[gw_addr] = 1'b1;
      end

      if (uw.stack_op == SK_PUSH && uw.grid_wr != GW_START) begin
         cur_row_in = new_row;
         cur_col_in = new_col;
         if (cnt_room) begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      if (uw.stack_op == SK_POP) begin
         cur_row_in = st_q[ENTRY_W-1 -: ROW_W];
         cur_col_in = st_q[COL_W-1:0];
         count_in   = cnt_m1;
         if (cnt_m1 == '0) begin
            done_in = 1'b1;
         end
      end

      case (uw.jump)
         JC_NEXT:   upc_in = upc_type'(upc_ff + 4'd1);
         JC_ALWAYS: upc_in = uw.target;
         JC_DISPATCH: begin
            if (req_accept) begin
               case (req_tuser)
                  ACT_START: upc_in = UP_START;
                  ACT_STEP:  upc_in = UP_CHECK;
                  ACT_READ:  upc_in = UP_READ;
                  default:   upc_in = UP_RESP;
               endcase
            end
         end
         JC_DONE: upc_in = done_ff ? uw.target : upc_type'(upc_ff + 4'd1);
         JC_MOVES: begin
            if (cand_mask != 4'd0) begin
               upc_in = uw.target;
            end else if (count_ff == '0) begin
               done_in = 1'b1;
               upc_in  = UP_RESP;
            end else begin
               upc_in = upc_type'(upc_ff + 4'd1);
            end
         end
         JC_POP: upc_in = (cnt_m1 == '0) ? UP_RESP : uw.target;
         JC_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               upc_in   = uw.target;
            end
         end
         default: upc_in = UP_IDLE;
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_load ? {bits_ff, done_ff, dir_ff, POS_W'(cur_col_ff),
                                 POS_W'(cur_row_ff)}
                              : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UP_IDLE;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b1;
         count_ff     <= '0;
         cur_row_ff   <= ROW_W'(1);
         cur_col_ff   <= COL_W'(1);
         valid_ff     <= '0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
         count_ff     <= count_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rd_valid_ff <= rd_valid_in;
      dir_ff      <= dir_in;
      bits_ff     <= bits_in;
      rnd_ff      <= rnd_in;
      idx_ff      <= idx_in;
      row_s_ff    <= row_s_in;
      row_n_ff    <= row_n_in;
      row_c_ff    <= row_c_in;
   end

   rdmc_ram #(
      .WIDTH (GRID_W),
      .DEPTH (GRID_H)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (gw_en),
      .wr_addr (gw_addr),
      .wr_data (gw_data),
      .rd_en   (gr_en),
      .rd_addr (gr_addr),
      .rd_data (gr_q)
   );

   rdmc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (cnt_m1[STK_AW-1:0]),
      .rd_data (st_q)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count above depth");

   a_active_has_stack: assert property (@(posedge clock) disable iff (reset)
      !done_ff |-> count_ff != '0)
      else $error("maze active with empty stack");

   a_cell_odd: assert property (@(posedge clock) disable iff (reset)
      cur_row_ff[0] && cur_col_ff[0])
      else $error("current cell not on odd coordinates");

   a_carve_has_move: assert property (@(posedge clock) disable iff (reset)
      upc_ff == UP_CARVE0 |-> cand_mask != 4'd0)
      else $error("carve entered without a legal move");

   a_load_only_in_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> upc_ff == UP_RESP)
      else $error("result loaded outside response step");

endmodule

`default_nettype wire

// ===== tb/sv/random_dfs_maze_carver_checker.sv =====
// Stream monitor for the maze carver: models the carving, predicts every response, compares it.
`timescale 1ns / 1ps

module random_dfs_maze_carver_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // [14:0] random_value, [18:15] row_index, [23:19] zero
   input  logic [rdmc_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [rdmc_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [3:0] cell_row, [7:4] cell_col, [9:8] direction, [10] finished, [23:11] row_bits
   input  logic [rdmc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              error_count,
   output int                              pending_count,
   output int                              mazes_completed
);

   import rdmc_pkg::*;

   typedef struct packed {
      logic [BITS_W-1:0] bits;
      logic              fin;
      logic [1:0]        dir;
      logic [POS_W-1:0]  col;
      logic [POS_W-1:0]  row;
   } cell_report_type;

   cell_report_type expected_reports[$];
   cell_report_type want;
   cell_report_type got;
   cell_report_type next_report;

   logic [GRID_W-1:0] wall_map [GRID_H];
   int                trail_row [STACK_DEPTH];
   int                trail_col [STACK_DEPTH];
   int                trail_len;
   int                cur_row;
   int                cur_col;
   logic              maze_done;
   int                errs;
   int                completions;

   function automatic bit is_wall(int r, int c);
      return (r < GRID_H && c < GRID_W) ? wall_map[r][c] : 1'b0;
   endfunction

   function automatic void open_cell(int r, int c);
      if (r < GRID_H && c < GRID_W) wall_map[r][c] = 1'b0;
   endfunction

   function automatic void push_cell(int r, int c);
      if (trail_len < STACK_DEPTH) begin
         trail_row[trail_len] = r;
         trail_col[trail_len] = c;
         trail_len++;
      end
   endfunction

   function automatic void clear_maze();
      for (int i = 0; i < GRID_H; i++) wall_map[i] = '1;
      trail_len = 0;
      cur_row   = 1;
      cur_col   = 1;
      maze_done = 1'b1;
   endfunction

   // backtrack until a move exists, then take move rnd mod count
   function automatic dir_type carve_step(input logic [RND_W-1:0] rnd);
      dir_type moves [4];
      int      n;
      int      r;
      int      c;
      dir_type d;
      for (int guard = 0; guard <= STACK_DEPTH + 1; guard++) begin
         if (maze_done) return DIR_SOUTH;
         n = 0;
         r = cur_row;
         c = cur_col;
         if (r + 2 < GRID_H - 1 && is_wall(r + 2, c)) begin
            moves[n] = DIR_SOUTH;
            n++;
         end
         if (r >= 3 && is_wall(r - 2, c)) begin
            moves[n] = DIR_NORTH;
            n++;
         end
         if (c >= 3 && is_wall(r, c - 2)) begin
            moves[n] = DIR_WEST;
            n++;
         end
         if (c + 2 < GRID_W - 1 && is_wall(r, c + 2)) begin
            moves[n] = DIR_EAST;
            n++;
         end
         if (n > 0) begin
            d = moves[int'(rnd) % n];
            case (d)
               DIR_SOUTH: begin
                  open_cell(r + 1, c);
                  r += 2;
               end
               DIR_NORTH: begin
                  open_cell(r - 1, c);
                  r -= 2;
               end
               DIR_WEST: begin
                  open_cell(r, c - 1);
                  c -= 2;
               end
               default: begin
                  open_cell(r, c + 1);
                  c += 2;
               end
            endcase
            open_cell(r, c);
            cur_row = r;
            cur_col = c;
            push_cell(r, c);
            return d;
         end
         if (trail_len == 0) begin
            maze_done = 1'b1;
            return DIR_SOUTH;
         end
         trail_len--;
         cur_row = trail_row[trail_len];
         cur_col = trail_col[trail_len];
         if (trail_len == 0) maze_done = 1'b1;
      end
      maze_done = 1'b1;
      return DIR_SOUTH;
   endfunction

   function automatic cell_report_type predict_report(input logic [1:0] act,
                                                      input logic [RND_W-1:0] rnd,
                                                      input logic [IDX_W-1:0] idx);
      cell_report_type rep;
      logic            was_done;
      rep      = '0;
      was_done = maze_done;
      case (act)
         ACT_START: begin
            clear_maze();
            maze_done = 1'b0;
            open_cell(1, 1);
            push_cell(1, 1);
         end
         ACT_STEP: rep.dir = carve_step(rnd);
         ACT_READ: if (idx < GRID_H) rep.bits = BITS_W'(wall_map[idx]);
         default: ;
      endcase
      if (act == ACT_STEP && !was_done && maze_done) completions++;
      rep.row = POS_W'(cur_row);
      rep.col = POS_W'(cur_col);
      rep.fin = maze_done;
      return rep;
   endfunction

   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         errs++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_maze();
         expected_reports.delete();
         errs        = 0;
         completions = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $error("response transfer with no request outstanding: 0x%06h", rsp_tdata);
               errs++;
            end else begin
               want = expected_reports.pop_front();
               got  = cell_report_type'(rsp_tdata);
               check_field("cell_row", want.row, got.row);
               check_field("cell_col", want.col, got.col);
               check_field("direction", want.dir, got.dir);
               check_field("finished", want.fin, got.fin);
               check_field("row_bits", want.bits, got.bits);
            end
         end
         if (req_tvalid && req_tready) begin
            next_report = predict_report(req_tuser, req_tdata[RND_W-1:0],
                                         req_tdata[RND_W +: IDX_W]);
            expected_reports.insert(expected_reports.size(), next_report);
         end
      end
      error_count     <= errs;
      pending_count   <= expected_reports.size();
      mazes_completed <= completions;
   end

endmodule

// ===== tb/sv/random_dfs_maze_carver_tb.sv =====
// Top of the maze carver testbench: clock, reset, request and response traffic, verdict.
`timescale 1ns / 1ps

module random_dfs_maze_carver_tb;
   import rdmc_pkg::*;

   localparam int ITEM_TARGET = 1250;
   localparam int IDLE_LIMIT  = 2000;
   localparam int LONG_HOLD   = 300;
   localparam logic [REQ_USER_W-1:0] ACT_UNUSED = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int error_count;
   int pending_count;
   int mazes_completed;
   int items_sent  = 0;
   int starts_sent = 0;
   int steps_sent  = 0;
   int reads_sent  = 0;
   int burst_left  = 0;
   bit long_hold_req = 1'b0;

   random_dfs_maze_carver u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   random_dfs_maze_carver_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .mazes_completed (mazes_completed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_item(input logic [REQ_USER_W-1:0] act, input logic [RND_W-1:0] rnd,
                            input logic [IDX_W-1:0] idx);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= REQ_DATA_W'({idx, rnd});
      do @(posedge clock); while (!req_tready);
      items_sent++;
      case (act)
         ACT_START: starts_sent++;
         ACT_STEP:  steps_sent++;
         ACT_READ:  reads_sent++;
         default: ;
      endcase
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // response side: stall pattern changes every span, one long hold-off on request
   initial begin
      int mode;
      int span;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(20, 150);
         repeat (span) begin
            @(posedge clock);
            if (long_hold_req && !hold_done) begin
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
               hold_done = 1'b1;
            end
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("random_dfs_maze_carver_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int roll;
      int run_len;
      bit paused;
      paused = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // step before any start, reads and unused code on the reset grid
      send_item(ACT_STEP, 15'd0, 4'd0);
      send_item(ACT_READ, 15'd0, 4'd0);
      send_item(ACT_READ, 15'h7FFF, 4'd15);
      send_item(ACT_UNUSED, 15'h7FFF, 4'd15);
      send_item(ACT_START, 15'd0, 4'd0);
      send_item(ACT_READ, 15'd0, 4'd1);
      send_item(ACT_STEP, 15'd0, 4'd0);
      send_item(ACT_STEP, 15'h7FFF, 4'd15);
      send_item(ACT_STEP, 15'h5555, 4'd5);
      send_item(ACT_STEP, 15'h2AAA, 4'd10);
      send_item(ACT_UNUSED, 15'd0, 4'd0);
      send_item(ACT_READ, 15'd0, 4'd10);
      send_item(ACT_READ, 15'd0, 4'd11);
      send_item(ACT_START, 15'h7FFF, 4'd15);
      send_item(ACT_STEP, 15'd1, 4'd0);
      send_item(ACT_STEP, 15'd2, 4'd0);
      send_item(ACT_READ, 15'd0, 4'd2);
      send_item(ACT_READ, 15'd0, 4'd5);

      while (items_sent < ITEM_TARGET) begin
         if (!long_hold_req && items_sent >= 300) long_hold_req <= 1'b1;
         if (!paused && items_sent >= 700) begin
            drain();
            paused = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 85) begin
            send_item(ACT_START, RND_W'($urandom_range(0, 32767)),
                      IDX_W'($urandom_range(0, 15)));
            run_len = $urandom_range(30, 90);
            repeat (run_len) begin
               roll = $urandom_range(0, 99);
               if (roll < 16)
                  send_item(ACT_READ, RND_W'($urandom_range(0, 32767)),
                            IDX_W'($urandom_range(0, 15)));
               else if (roll < 19)
                  send_item(ACT_UNUSED, RND_W'($urandom_range(0, 32767)),
                            IDX_W'($urandom_range(0, 15)));
               else
                  send_item(ACT_STEP, RND_W'($urandom_range(0, 32767)),
                            IDX_W'($urandom_range(0, 15)));
            end
         end else begin
            repeat ($urandom_range(3, 15))
               send_item(REQ_USER_W'($urandom_range(0, 3)), RND_W'($urandom_range(0, 32767)),
                         IDX_W'($urandom_range(0, 15)));
         end
      end

      drain();
      repeat (40) @(posedge clock);
      $display("covered %0d requests: %0d starts, %0d carve steps, %0d row reads",
               items_sent, starts_sent, steps_sent, reads_sent);
      $display("%0d mazes carved to completion, with a long response hold-off and a drain pause",
               mazes_completed);
      if (error_count == 0 && pending_count == 0) begin
         $display("random_dfs_maze_carver_tb OK");
      end else begin
         $display("random_dfs_maze_carver_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/rdmc_pkg.sv
rtl/core/rdmc_ram.sv
rtl/core/random_dfs_maze_carver.sv
tb/sv/random_dfs_maze_carver_checker.sv
tb/sv/random_dfs_maze_carver_tb.sv
